@@ hw/rtl/chacha_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the ChaCha block keystream generator.
// No dependencies.
package chacha_pkg;

    typedef logic [31:0] word_t;
    typedef word_t [15:0] state_t;

    localparam int ROUND_COUNT_DEF = 20;
    localparam int CHUNK_COUNT     = 8;
    localparam int CHUNK_IDX_W     = $clog2(CHUNK_COUNT);

    // "expand 32-byte k"
    localparam word_t [3:0] SIGMA = {
        32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865
    };

    typedef struct packed {
        logic busy;
        logic done;
    } core_status_t;

endpackage

@@ hw/rtl/chacha_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces: key/nonce request words and keystream words.
// No dependencies.
interface chacha_req_if;
    logic        valid;
    logic        ready;
    logic [63:0] key_part0;
    logic [63:0] key_part1;
    logic [63:0] key_part2;
    logic [63:0] key_part3;
    logic [63:0] nonce_low;
    logic [63:0] nonce_high;

    modport source (
        output valid, key_part0, key_part1, key_part2, key_part3, nonce_low, nonce_high,
        input  ready
    );
    modport sink (
        input  valid, key_part0, key_part1, key_part2, key_part3, nonce_low, nonce_high,
        output ready
    );
endinterface

interface chacha_ks_if;
    logic        valid;
    logic        ready;
    logic [63:0] stream_chunk;
    logic        chunk_last;

    modport source (
        output valid, stream_chunk, chunk_last,
        input  ready
    );
    modport sink (
        input  valid, stream_chunk, chunk_last,
        output ready
    );
endinterface

@@ hw/rtl/chacha20_block_keystream_top.sv @@
`timescale 1ns / 1ps
// ChaCha block keystream generator top: request capture, core control and
// keystream word output. Depends on chacha_pkg, chacha_if and chacha_core.
//
//  channel    dir   payload                                      handshake
//  request    sink  key_part0..3, nonce_low, nonce_high (64 b)   valid/ready
//  keystream  src   stream_chunk (64 b), chunk_last              valid/ready
//
// One block takes an accept cycle, 2*ROUND_COUNT round steps (half a
// quarter-round per lane per cycle in four shared lanes), an add cycle
// and a done handoff cycle, then 8 keystream words.
// request.ready is high only while no block is in flight.
// Keystream stalls hold the current word; reset returns to idle at once.
module chacha20_block_keystream_top
    import chacha_pkg::*;
#(
    parameter int ROUND_COUNT = ROUND_COUNT_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    chacha_req_if.sink    request,
    chacha_ks_if.source   keystream
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_EMIT
    } top_state_t;

    top_state_t             state_reg;
    logic [CHUNK_IDX_W-1:0] chunk_idx_reg;

    logic         accept;
    state_t       init_state;
    state_t       result;
    core_status_t status;

    assign accept = request.valid && request.ready;

    assign init_state = {
        request.nonce_high, request.nonce_low,
        request.key_part3, request.key_part2, request.key_part1, request.key_part0,
        SIGMA
    };

    chacha_core #(
        .ROUND_COUNT (ROUND_COUNT)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (accept),
        .init_state (init_state),
        .result     (result),
        .status     (status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            chunk_idx_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_RUN;
                    end
                end
                S_RUN:
                begin
                    if (status.done)
                    begin
                        state_reg     <= S_EMIT;
                        chunk_idx_reg <= '0;
                    end
                end
                S_EMIT:
                begin
                    if (keystream.ready)
                    begin
                        chunk_idx_reg <= chunk_idx_reg + 1'b1;
                        if (chunk_idx_reg == CHUNK_IDX_W'(CHUNK_COUNT - 1))
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign request.ready          = (state_reg == S_IDLE) && !status.busy;
    assign keystream.valid        = (state_reg == S_EMIT);
    assign keystream.stream_chunk = {result[{chunk_idx_reg, 1'b1}], result[{chunk_idx_reg, 1'b0}]};
    assign keystream.chunk_last   = (chunk_idx_reg == CHUNK_IDX_W'(CHUNK_COUNT - 1));

endmodule

@@ hw/rtl/chacha_qr_half.sv @@
`timescale 1ns / 1ps
// Half of a ChaCha quarter-round: two add/xor/rotate steps.
// Depends on chacha_pkg.
module chacha_qr_half
    import chacha_pkg::*;
(
    input  logic  second,
    input  word_t a,
    input  word_t b,
    input  word_t c,
    input  word_t d,
    output word_t a_out,
    output word_t b_out,
    output word_t c_out,
    output word_t d_out
);

    word_t a1;
    word_t d1;
    word_t d2;
    word_t c1;
    word_t b1;
    word_t b2;

    always_comb
    begin
        a1 = a + b;
        d1 = d ^ a1;
        d2 = second ? {d1[23:0], d1[31:24]} : {d1[15:0], d1[31:16]};
        c1 = c + d2;
        b1 = b ^ c1;
        b2 = second ? {b1[24:0], b1[31:25]} : {b1[19:0], b1[31:20]};
    end

    assign a_out = a1;
    assign b_out = b2;
    assign c_out = c1;
    assign d_out = d2;

endmodule

@@ hw/rtl/chacha_core.sv @@
`timescale 1ns / 1ps
// ChaCha round sequencer: four half quarter-round lanes reused every cycle,
// then the feed-forward add. Depends on chacha_pkg and chacha_qr_half.
module chacha_core
    import chacha_pkg::*;
#(
    parameter int ROUND_COUNT = ROUND_COUNT_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  state_t       init_state,
    output state_t       result,
    output core_status_t status
);

    localparam int STEP_COUNT = 2 * ROUND_COUNT;
    localparam int STEP_W     = $clog2(STEP_COUNT);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(STEP_COUNT - 1);

    typedef enum logic [1:0] {
        C_IDLE,
        C_ROUND,
        C_ADD
    } core_state_t;

    core_state_t       state_reg;
    logic [STEP_W-1:0] step_reg;
    logic              done_reg;
    state_t            w_reg;
    state_t            init_reg;

    word_t [3:0] lane_a;
    word_t [3:0] lane_b;
    word_t [3:0] lane_c;
    word_t [3:0] lane_d;
    word_t [3:0] out_a;
    word_t [3:0] out_b;
    word_t [3:0] out_c;
    word_t [3:0] out_d;
    state_t      round_next;
    state_t      sum_next;
    logic        diag;

    assign diag = step_reg[1];

    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            lane_a[j] = w_reg[j];
            lane_b[j] = diag ? w_reg[4 + ((j + 1) & 3)] : w_reg[4 + j];
            lane_c[j] = diag ? w_reg[8 + ((j + 2) & 3)] : w_reg[8 + j];
            lane_d[j] = diag ? w_reg[12 + ((j + 3) & 3)] : w_reg[12 + j];
        end
    end

    for (genvar g = 0; g < 4; g++)
    begin : g_lane
        chacha_qr_half u_qr (
            .second (step_reg[0]),
            .a      (lane_a[g]),
            .b      (lane_b[g]),
            .c      (lane_c[g]),
            .d      (lane_d[g]),
            .a_out  (out_a[g]),
            .b_out  (out_b[g]),
            .c_out  (out_c[g]),
            .d_out  (out_d[g])
        );
    end

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            round_next[k]      = out_a[k];
            round_next[4 + k]  = diag ? out_b[(k + 3) & 3] : out_b[k];
            round_next[8 + k]  = diag ? out_c[(k + 2) & 3] : out_c[k];
            round_next[12 + k] = diag ? out_d[(k + 1) & 3] : out_d[k];
        end
        for (int k = 0; k < 16; k++)
        begin
            sum_next[k] = w_reg[k] + init_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                C_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= C_ROUND;
                        step_reg  <= '0;
                    end
                end
                C_ROUND:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_LAST)
                    begin
                        state_reg <= C_ADD;
                    end
                end
                C_ADD:
                begin
                    state_reg <= C_IDLE;
                    done_reg  <= 1'b1;
                end
                default:
                begin
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == C_IDLE && start)
        begin
            w_reg    <= init_state;
            init_reg <= init_state;
        end
        else if (state_reg == C_ROUND)
        begin
            w_reg <= round_next;
        end
        else if (state_reg == C_ADD)
        begin
            w_reg <= sum_next;
        end
    end

    assign result      = w_reg;
    assign status.busy = (state_reg != C_IDLE);
    assign status.done = done_reg;

endmodule

@@ hw/rtl/chacha_checker.sv @@
`timescale 1ns / 1ps
// Port-level assertions for the ChaCha keystream top, bound to it below.
// Depends on chacha20_block_keystream_top and chacha_if.
module chacha_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        ks_valid,
    input logic        ks_ready,
    input logic [63:0] ks_chunk,
    input logic        ks_last
);

    // one block in flight: accept drops ready
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while a block is in flight");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        ks_valid |-> !req_ready)
        else $error("request ready while keystream words pending");

    a_no_early_word: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !ks_valid)
        else $error("keystream word right after accept");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        ks_valid && ks_ready && ks_last |=> !ks_valid)
        else $error("keystream word after last word");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ks_valid && !ks_ready |=> ks_valid && $stable(ks_chunk) && $stable(ks_last))
        else $error("stalled keystream word changed");

endmodule

bind chacha20_block_keystream_top chacha_checker u_chacha_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (request.valid),
    .req_ready (request.ready),
    .ks_valid  (keystream.valid),
    .ks_ready  (keystream.ready),
    .ks_chunk  (keystream.stream_chunk),
    .ks_last   (keystream.chunk_last)
);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for chacha20_block_keystream_top: drives key/nonce words,
// predicts the 64-byte ChaCha keystream of each and checks every output word.
// Depends on chacha_pkg, chacha_if and the DUT sources.
module tb_top
    import chacha_pkg::*;
();

    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 12;
    localparam int ROUNDS        = ROUND_COUNT_DEF;
    localparam int HOLD_CYCLES   = 300;
    localparam int IDLE_LIMIT    = 2000;
    localparam int DRAIN_CYCLES  = 60;
    localparam int RANDOM_FAST   = 30;
    localparam int RANDOM_PRESS  = 5;
    localparam int RANDOM_JITTER = 32;
    localparam int RANDOM_SLOW   = 27;
    localparam int DIRECTED_N    = 16;

    typedef struct packed {
        logic [63:0] key_part0;
        logic [63:0] key_part1;
        logic [63:0] key_part2;
        logic [63:0] key_part3;
        logic [63:0] nonce_low;
        logic [63:0] nonce_high;
    } key_nonce_t;

    typedef struct packed {
        logic [63:0] chunk;
        logic        last;
    } ks_word_t;

    typedef enum int { SEND_BACK_TO_BACK, SEND_JITTER, SEND_SPARSE } send_mode_t;
    typedef enum int { SINK_OPEN, SINK_CHOPPY, SINK_SLUGGISH } sink_mode_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    chacha_req_if request ();
    chacha_ks_if  keystream ();

    chacha20_block_keystream_top #(
        .ROUND_COUNT(ROUNDS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request),
        .keystream (keystream)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    ks_word_t   keystream_due [$];
    ks_word_t   due_word;
    int         error_count   = 0;
    int         blocks_taken  = 0;
    int         words_checked = 0;
    int         idle_cycles   = 0;
    bit         hold_req      = 1'b0;
    sink_mode_t sink_mode     = SINK_OPEN;

    key_nonce_t directed_rows [DIRECTED_N] = '{
        '{64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0},
        '{64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff,
          64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff},
        // published block-function vector: key 00..1f, counter 1
        '{64'h0706_0504_0302_0100, 64'h0f0e_0d0c_0b0a_0908, 64'h1716_1514_1312_1110,
          64'h1f1e_1d1c_1b1a_1918, 64'h0900_0000_0000_0001, 64'h0000_0000_4a00_0000},
        '{64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555,
          64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555},
        '{64'haaaa_aaaa_aaaa_aaaa, 64'haaaa_aaaa_aaaa_aaaa, 64'haaaa_aaaa_aaaa_aaaa,
          64'haaaa_aaaa_aaaa_aaaa, 64'haaaa_aaaa_aaaa_aaaa, 64'haaaa_aaaa_aaaa_aaaa},
        '{64'h1, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0},
        '{64'h0, 64'h0, 64'h0, 64'h8000_0000_0000_0000, 64'h0, 64'h0},
        '{64'h0, 64'h0, 64'h0, 64'h0, 64'h1, 64'h0},
        '{64'h0, 64'h0, 64'h0, 64'h0, 64'h0000_0000_ffff_ffff, 64'h0},
        '{64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h8000_0000_0000_0000},
        '{64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff,
          64'hffff_ffff_ffff_ffff, 64'h0, 64'h0},
        '{64'h0, 64'h0, 64'h0, 64'h0, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff},
        '{64'h0706_0504_0302_0100, 64'h0f0e_0d0c_0b0a_0908, 64'h1716_1514_1312_1110,
          64'h1f1e_1d1c_1b1a_1918, 64'h0, 64'h0},
        '{64'h8000_0000_8000_0000, 64'h8000_0000_8000_0000, 64'h8000_0000_8000_0000,
          64'h8000_0000_8000_0000, 64'h8000_0000_8000_0000, 64'h8000_0000_8000_0000},
        '{64'h0000_0001_0000_0001, 64'h0000_0001_0000_0001, 64'h0000_0001_0000_0001,
          64'h0000_0001_0000_0001, 64'h0000_0001_0000_0001, 64'h0000_0001_0000_0001},
        '{64'hffff_ffff_0000_0000, 64'hffff_ffff_0000_0000, 64'hffff_ffff_0000_0000,
          64'hffff_ffff_0000_0000, 64'h0000_0000_ffff_ffff, 64'h0000_0000_ffff_ffff}
    };

    function automatic word_t rotl(word_t x, int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic state_t quarter_round(state_t s, int a, int b, int c, int d);
        s[a] = s[a] + s[b];
        s[d] = rotl(s[d] ^ s[a], 16);
        s[c] = s[c] + s[d];
        s[b] = rotl(s[b] ^ s[c], 12);
        s[a] = s[a] + s[b];
        s[d] = rotl(s[d] ^ s[a], 8);
        s[c] = s[c] + s[d];
        s[b] = rotl(s[b] ^ s[c], 7);
        return s;
    endfunction

    task automatic queue_keystream(input key_nonce_t kn);
        logic [5:0][63:0] parts;
        state_t           init_s;
        state_t           s;
        ks_word_t         w;
        parts = {kn.nonce_high, kn.nonce_low, kn.key_part3,
                 kn.key_part2, kn.key_part1, kn.key_part0};
        for (int i = 0; i < 4; i++)
            init_s[i] = SIGMA[i];
        for (int i = 0; i < 6; i++)
        begin
            init_s[4 + 2 * i] = parts[i][31:0];
            init_s[5 + 2 * i] = parts[i][63:32];
        end
        s = init_s;
        for (int r = 0; r < ROUNDS; r++)
        begin
            if (r % 2 == 0)
            begin
                s = quarter_round(s, 0, 4, 8, 12);
                s = quarter_round(s, 1, 5, 9, 13);
                s = quarter_round(s, 2, 6, 10, 14);
                s = quarter_round(s, 3, 7, 11, 15);
            end
            else
            begin
                s = quarter_round(s, 0, 5, 10, 15);
                s = quarter_round(s, 1, 6, 11, 12);
                s = quarter_round(s, 2, 7, 8, 13);
                s = quarter_round(s, 3, 4, 9, 14);
            end
        end
        for (int i = 0; i < 16; i++)
            s[i] = s[i] + init_s[i];
        for (int i = 0; i < CHUNK_COUNT; i++)
        begin
            w.chunk = {s[2 * i + 1], s[2 * i]};
            w.last  = (i == CHUNK_COUNT - 1);
            keystream_due.push_back(w);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] MISMATCH %s after %0d words: got %h want %h",
                 $realtime, what, words_checked, got, want);
        error_count++;
    endtask

    function automatic logic [63:0] random_field();
        case ($urandom_range(0, 9))
            0:       return 64'h0;
            1:       return 64'hffff_ffff_ffff_ffff;
            2:       return 64'h1 << $urandom_range(0, 63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic key_nonce_t random_request();
        key_nonce_t kn;
        kn.key_part0  = random_field();
        kn.key_part1  = random_field();
        kn.key_part2  = random_field();
        kn.key_part3  = random_field();
        kn.nonce_low  = random_field();
        kn.nonce_high = random_field();
        return kn;
    endfunction

    function automatic int pick_gap(send_mode_t m);
        case (m)
            SEND_BACK_TO_BACK: return 0;
            SEND_JITTER:       return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
            default:           return ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
                                                                 : $urandom_range(0, 3);
        endcase
    endfunction

    // valid stays high across back-to-back words; dropped only ahead of a gap
    task automatic offer(input key_nonce_t kn, input int gap);
        if (gap > 0)
        begin
            request.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        request.valid      <= 1'b1;
        request.key_part0  <= kn.key_part0;
        request.key_part1  <= kn.key_part1;
        request.key_part2  <= kn.key_part2;
        request.key_part3  <= kn.key_part3;
        request.nonce_low  <= kn.nonce_low;
        request.nonce_high <= kn.nonce_high;
        do @(posedge clk); while (!request.ready);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (request.valid && request.ready)
            begin
                queue_keystream({request.key_part0, request.key_part1, request.key_part2,
                                 request.key_part3, request.nonce_low, request.nonce_high});
                blocks_taken++;
            end
            if (keystream.valid && keystream.ready)
            begin
                if (keystream_due.size() == 0)
                    report_mismatch("unexpected word", keystream.stream_chunk, 64'h0);
                else
                begin
                    due_word = keystream_due.pop_front();
                    if (keystream.stream_chunk !== due_word.chunk)
                        report_mismatch("stream_chunk", keystream.stream_chunk, due_word.chunk);
                    if (keystream.chunk_last !== due_word.last)
                        report_mismatch("chunk_last", {63'h0, keystream.chunk_last},
                                        {63'h0, due_word.last});
                end
                words_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((request.valid && request.ready) || (keystream.valid && keystream.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("[%0t] timeout: %0d idle cycles, %0d words still due",
                         $realtime, idle_cycles, keystream_due.size());
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin : sink
        int hold_left;
        hold_left = 0;
        keystream.ready <= 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                keystream.ready <= 1'b0;
            end
            else
            begin
                case (sink_mode)
                    SINK_OPEN:
                        keystream.ready <= 1'b1;
                    SINK_CHOPPY:
                        keystream.ready <= ($urandom_range(0, 3) != 0);
                    default:
                    begin
                        if ($urandom_range(0, 29) == 0)
                        begin
                            hold_left = $urandom_range(10, 60);
                            keystream.ready <= 1'b0;
                        end
                        else
                            keystream.ready <= ($urandom_range(0, 4) != 0);
                    end
                endcase
            end
        end
    end

    initial
    begin : stimulus
        request.valid      <= 1'b0;
        request.key_part0  <= '0;
        request.key_part1  <= '0;
        request.key_part2  <= '0;
        request.key_part3  <= '0;
        request.nonce_low  <= '0;
        request.nonce_high <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_N; i++)
        begin
            sink_mode = (i < DIRECTED_N / 2) ? SINK_OPEN : SINK_CHOPPY;
            offer(directed_rows[i], pick_gap(SEND_JITTER));
        end

        sink_mode = SINK_OPEN;
        for (int i = 0; i < RANDOM_FAST; i++)
            offer(random_request(), pick_gap(SEND_BACK_TO_BACK));

        // long output hold-off while requests keep coming
        hold_req = 1'b1;
        for (int i = 0; i < RANDOM_PRESS; i++)
            offer(random_request(), pick_gap(SEND_BACK_TO_BACK));

        sink_mode = SINK_CHOPPY;
        for (int i = 0; i < RANDOM_JITTER; i++)
            offer(random_request(), pick_gap(SEND_JITTER));

        sink_mode = SINK_SLUGGISH;
        for (int i = 0; i < RANDOM_SLOW; i++)
            offer(random_request(), pick_gap(SEND_SPARSE));

        request.valid <= 1'b0;
        sink_mode = SINK_OPEN;
        while (keystream_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d key/nonce blocks (%0d directed) and %0d keystream words,",
                 blocks_taken, DIRECTED_N, words_checked);
        $display("with back-to-back, jittered and sparse traffic and a %0d-cycle output hold.",
                 HOLD_CYCLES);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/chacha_pkg.sv
hw/rtl/chacha_if.sv
hw/rtl/chacha_qr_half.sv
hw/rtl/chacha_core.sv
hw/rtl/chacha20_block_keystream_top.sv
hw/rtl/chacha_checker.sv
tb/tb_top.sv
